/* hw/rtl/lms_adaptive_fir_unit_assert.svh */
// Assertion macros for the LMS adaptive FIR unit.
// Used by the top level; each macro expects signals named clock and reset in scope.
`ifndef LMS_ADAPTIVE_FIR_UNIT_ASSERT_SVH
`define LMS_ADAPTIVE_FIR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMSFIR_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lmsfir: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LMSFIR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lmsfir: next-cycle check failed");

// The condition must hold in every cycle outside reset.
`define LMSFIR_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("lmsfir: invariant failed");

`endif

/* hw/rtl/lmsfir_pkg.sv */
// Shared constants, types and sequencer-to-datapath control struct for the LMS FIR unit.
// No dependencies; imported by the controller, the datapath and the top level.
package lmsfir_pkg;

   // Filter geometry and number formats.
   localparam int TAPS         = 128;
   localparam int SAMPLE_WIDTH = 16;
   localparam int COEF_WIDTH   = 32;
   localparam int STEP_WIDTH   = 16;
   localparam int SAMP_FRAC    = SAMPLE_WIDTH - 1;
   localparam int COEF_FRAC    = COEF_WIDTH - 4;
   localparam int UPD_SHIFT    = STEP_WIDTH + 2 * SAMP_FRAC - COEF_FRAC;

   localparam int ADDR_WIDTH   = $clog2(TAPS);
   localparam int PIPE_DEPTH   = 2;

   // Internal word widths, each just wide enough for its value range.
   localparam int MERR_WIDTH   = STEP_WIDTH + SAMPLE_WIDTH;
   localparam int MULA_WIDTH   = (COEF_WIDTH > MERR_WIDTH) ? COEF_WIDTH : MERR_WIDTH;
   localparam int PROD_WIDTH   = MULA_WIDTH + SAMPLE_WIDTH;
   localparam int ACC_WIDTH    = PROD_WIDTH + ADDR_WIDTH;
   localparam int EST_WIDTH    = ACC_WIDTH - COEF_FRAC + 1;
   localparam int ERR_WIDTH    = EST_WIDTH + 1;
   localparam int DELTA_WIDTH  = PROD_WIDTH - UPD_SHIFT + 1;
   localparam int SUM_WIDTH    = ((DELTA_WIDTH > COEF_WIDTH) ? DELTA_WIDTH : COEF_WIDTH) + 1;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_DATA_WIDTH = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;

   typedef logic [ADDR_WIDTH-1:0] addr_type;

   localparam addr_type LAST_IDX  = ADDR_WIDTH'(TAPS - 1);
   localparam addr_type PIPE_LAST = ADDR_WIDTH'(PIPE_DEPTH - 1);

   localparam logic [STEP_WIDTH-1:0] STEP_RESET = STEP_WIDTH'(328);

   // Per-cycle commands from the sequencer to the datapath.
   typedef struct packed {
      logic     start;      // item transfer: clear accumulator and flag
      logic     dot_issue;  // dot-product reads issued at idx
      logic     upd_issue;  // coefficient-update reads issued at idx
      logic     finish;     // form estimate and error from the accumulator
      logic     scale;      // form step size times error
      logic     clear;      // clearing pass writes zero at idx
      logic     out_load;   // move the result into the output register
      addr_type idx;        // tap index of the current access
   } ctl_type;

endpackage

/* hw/rtl/lmsfir_ram.sv */
// Generic single-clock RAM: one write port, one read port with registered read data.
// Stand-alone; used for the sample history and the coefficient store.
module lmsfir_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write first port, read second port; read data is registered and appears in the cycle after the address.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/lmsfir_ctrl.sv */
// Sequencer for the LMS FIR unit: clearing pass, dot-product and update sweeps, handshakes.
// Depends on lmsfir_pkg; drives the history RAM and the datapath control struct.
module lmsfir_ctrl
   import lmsfir_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [SAMPLE_WIDTH-1:0] ref_sample,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output ctl_type                 ctl,
   output logic                    hist_we,
   output addr_type                hist_waddr,
   output logic [SAMPLE_WIDTH-1:0] hist_wdata,
   output addr_type                hist_raddr
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DOT,
      S_DOT_DRAIN,
      S_FINISH,
      S_SCALE,
      S_UPD,
      S_UPD_DRAIN,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   addr_type  idx_ff, idx_in;
   addr_type  hptr_ff, hptr_in;    // history slot of the newest sample
   addr_type  haddr_ff, haddr_in;  // history slot read this cycle
   logic      rsp_valid_ff, rsp_valid_in;
   addr_type  next_hptr;
   addr_type  prev_haddr;

   // Circular history pointer arithmetic.
   always_comb begin
      next_hptr  = (hptr_ff == LAST_IDX) ? '0 : hptr_ff + 1'b1;
      prev_haddr = (haddr_ff == '0) ? LAST_IDX : haddr_ff - 1'b1;
   end

   // Next-state and command decode.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      hptr_in      = hptr_ff;
      haddr_in     = haddr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl          = '0;
      ctl.idx      = idx_ff;
      hist_we      = 1'b0;
      hist_waddr   = idx_ff;
      hist_wdata   = '0;
      req_ready    = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            // Zero one entry of each store per cycle.
            ctl.clear = 1'b1;
            hist_we   = 1'b1;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // The new sample overwrites the oldest slot.
               ctl.start  = 1'b1;
               hist_we    = 1'b1;
               hist_waddr = next_hptr;
               hist_wdata = ref_sample;
               hptr_in    = next_hptr;
               haddr_in   = next_hptr;
               idx_in     = '0;
               state_in   = S_DOT;
            end
         end
         S_DOT: begin
            ctl.dot_issue = 1'b1;
            idx_in        = idx_ff + 1'b1;
            haddr_in      = prev_haddr;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               haddr_in = hptr_ff;
               state_in = S_DOT_DRAIN;
            end
         end
         S_DOT_DRAIN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == PIPE_LAST) begin
               idx_in   = '0;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            ctl.finish = 1'b1;
            state_in   = S_SCALE;
         end
         S_SCALE: begin
            ctl.scale = 1'b1;
            state_in  = S_UPD;
         end
         S_UPD: begin
            ctl.upd_issue = 1'b1;
            idx_in        = idx_ff + 1'b1;
            haddr_in      = prev_haddr;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = S_UPD_DRAIN;
            end
         end
         S_UPD_DRAIN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == PIPE_LAST) begin
               idx_in   = '0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         hptr_ff      <= '0;
         haddr_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         hptr_ff      <= hptr_in;
         haddr_ff     <= haddr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign hist_raddr = haddr_ff;
   assign rsp_valid  = rsp_valid_ff;

endmodule

/* hw/rtl/lmsfir_dp.sv */
// Datapath of the LMS FIR unit: shared multiplier, accumulator, rounding and saturation.
// Depends on lmsfir_pkg; reads both RAMs and writes the coefficient RAM.
module lmsfir_dp
   import lmsfir_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  ctl_type                        ctl,
   input  logic        [STEP_WIDTH-1:0]   step_size,
   input  logic signed [SAMPLE_WIDTH-1:0] measured_sample,
   input  logic signed [COEF_WIDTH-1:0]   coef_rdata,
   input  logic signed [SAMPLE_WIDTH-1:0] hist_rdata,
   output logic                           coef_we,
   output addr_type                       coef_waddr,
   output logic        [COEF_WIDTH-1:0]   coef_wdata,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_estimate,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_error,
   output logic                           rsp_saturated
);

   // Pipeline control: stage 1 has RAM data, stage 2 has the product.
   logic     s1_dot_ff, s1_dot_in, s1_upd_ff, s1_upd_in;
   logic     s2_dot_ff, s2_dot_in, s2_upd_ff, s2_upd_in;
   addr_type s1_idx_ff, s1_idx_in, s2_idx_ff, s2_idx_in;

   logic signed [SAMPLE_WIDTH-1:0] meas_ff, meas_in;
   logic signed [PROD_WIDTH-1:0]   prod_ff, prod_in;
   logic signed [COEF_WIDTH-1:0]   coef2_ff, coef2_in;
   logic signed [ACC_WIDTH-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_WIDTH-1:0] est_ff, est_in, err_ff, err_in;
   logic                           sat_ff, sat_in;
   logic signed [MERR_WIDTH-1:0]   merr_ff, merr_in;
   logic signed [SAMPLE_WIDTH-1:0] out_est_ff, out_est_in, out_err_ff, out_err_in;
   logic                           out_sat_ff, out_sat_in;

   logic signed [MULA_WIDTH-1:0]   mul_a;
   logic signed [STEP_WIDTH:0]     step_s;
   logic signed [EST_WIDTH-1:0]    est_r;
   logic signed [ERR_WIDTH-1:0]    err_w;
   logic                           est_ovf, err_ovf, upd_ovf;
   logic signed [SAMPLE_WIDTH-1:0] est_sat, err_sat;
   logic signed [DELTA_WIDTH-1:0]  delta;
   logic signed [SUM_WIDTH-1:0]    sum;
   logic signed [COEF_WIDTH-1:0]   upd_coef;

   // One multiplier serves both sweeps: coefficient times sample, then
   // step-scaled error times sample.
   always_comb begin
      mul_a   = s1_upd_ff ? MULA_WIDTH'(merr_ff) : MULA_WIDTH'(coef_rdata);
      prod_in = mul_a * hist_rdata;
   end

   // Estimate rounds half up to sample precision; error uses the unsaturated estimate.
   always_comb begin
      est_r = EST_WIDTH'($signed(acc_ff[ACC_WIDTH-1:COEF_FRAC]))
            + EST_WIDTH'($signed({1'b0, acc_ff[COEF_FRAC-1]}));
      est_ovf = (|est_r[EST_WIDTH-1:SAMPLE_WIDTH-1]) && !(&est_r[EST_WIDTH-1:SAMPLE_WIDTH-1]);
      est_sat = est_ovf ? {est_r[EST_WIDTH-1], {(SAMPLE_WIDTH-1){~est_r[EST_WIDTH-1]}}}
                        : est_r[SAMPLE_WIDTH-1:0];
      err_w   = ERR_WIDTH'(meas_ff) - ERR_WIDTH'(est_r);
      err_ovf = (|err_w[ERR_WIDTH-1:SAMPLE_WIDTH-1]) && !(&err_w[ERR_WIDTH-1:SAMPLE_WIDTH-1]);
      err_sat = err_ovf ? {err_w[ERR_WIDTH-1], {(SAMPLE_WIDTH-1){~err_w[ERR_WIDTH-1]}}}
                        : err_w[SAMPLE_WIDTH-1:0];
      step_s  = $signed({1'b0, step_size});
   end

   // Coefficient update: round the delta, add it and saturate the sum to the
   // coefficient width.
   always_comb begin
      delta = DELTA_WIDTH'($signed(prod_ff[PROD_WIDTH-1:UPD_SHIFT]))
            + DELTA_WIDTH'($signed({1'b0, prod_ff[UPD_SHIFT-1]}));
      sum      = SUM_WIDTH'(coef2_ff) + SUM_WIDTH'(delta);
      upd_ovf  = (|sum[SUM_WIDTH-1:COEF_WIDTH-1]) && !(&sum[SUM_WIDTH-1:COEF_WIDTH-1]);
      upd_coef = upd_ovf ? {sum[SUM_WIDTH-1], {(COEF_WIDTH-1){~sum[SUM_WIDTH-1]}}}
                         : sum[COEF_WIDTH-1:0];
   end

   // Next values of the pipeline and result registers.
   always_comb begin
      s1_dot_in = ctl.dot_issue;
      s1_upd_in = ctl.upd_issue;
      s1_idx_in = ctl.idx;
      s2_dot_in = s1_dot_ff;
      s2_upd_in = s1_upd_ff;
      s2_idx_in = s1_idx_ff;
      coef2_in  = coef_rdata;
      meas_in   = ctl.start ? measured_sample : meas_ff;

      // The accumulator cannot overflow: 128 products of 48 bits fit in its width.
      acc_in = acc_ff;
      if (ctl.start) begin
         acc_in = '0;
      end else if (s2_dot_ff) begin
         acc_in = acc_ff + ACC_WIDTH'(prod_ff);
      end

      est_in = ctl.finish ? est_sat : est_ff;
      err_in = ctl.finish ? err_sat : err_ff;
      sat_in = sat_ff;
      if (ctl.start) begin
         sat_in = 1'b0;
      end else if (ctl.finish) begin
         sat_in = sat_ff || est_ovf || err_ovf;
      end else if (s2_upd_ff) begin
         sat_in = sat_ff || upd_ovf;
      end

      merr_in = ctl.scale ? step_s * err_ff : merr_ff;

      out_est_in = ctl.out_load ? est_ff : out_est_ff;
      out_err_in = ctl.out_load ? err_ff : out_err_ff;
      out_sat_in = ctl.out_load ? sat_ff : out_sat_ff;
   end

   // Coefficient write port: clearing pass or update write-back.
   always_comb begin
      coef_we    = ctl.clear || s2_upd_ff;
      coef_waddr = ctl.clear ? ctl.idx : s2_idx_ff;
      coef_wdata = ctl.clear ? '0 : upd_coef;
   end

   // Pipeline valid flags reset; payload registers do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_dot_ff <= 1'b0;
         s1_upd_ff <= 1'b0;
         s2_dot_ff <= 1'b0;
         s2_upd_ff <= 1'b0;
      end else begin
         s1_dot_ff <= s1_dot_in;
         s1_upd_ff <= s1_upd_in;
         s2_dot_ff <= s2_dot_in;
         s2_upd_ff <= s2_upd_in;
      end
      s1_idx_ff  <= s1_idx_in;
      s2_idx_ff  <= s2_idx_in;
      meas_ff    <= meas_in;
      prod_ff    <= prod_in;
      coef2_ff   <= coef2_in;
      acc_ff     <= acc_in;
      est_ff     <= est_in;
      err_ff     <= err_in;
      sat_ff     <= sat_in;
      merr_ff    <= merr_in;
      out_est_ff <= out_est_in;
      out_err_ff <= out_err_in;
      out_sat_ff <= out_sat_in;
   end

   assign rsp_estimate  = out_est_ff;
   assign rsp_error     = out_err_ff;
   assign rsp_saturated = out_sat_ff;

endmodule

/* hw/rtl/lms_adaptive_fir_unit.sv */
// LMS adaptive FIR filter with 128 taps, Q1.15 samples and Q4.28 coefficients. For each
// item a single shared multiplier reads one tap per cycle from the sample-history and
// coefficient RAMs, first for the dot product and then for the coefficient update. The
// pipeline drains after each sweep; estimate, error and step-scaled error are formed
// between the sweeps. req_tready is high again in the cycle the result enters the output
// register, so the next item overlaps a result still waiting. After reset a clearing pass
// zeroes both RAMs with req_tready low; step-size writes are taken at any time.
// Depends on lmsfir_pkg, lmsfir_ram, lmsfir_ctrl, lmsfir_dp and the assertion macro header.
`include "lms_adaptive_fir_unit_assert.svh"

module lms_adaptive_fir_unit
   import lmsfir_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,  // ref_sample, measured_sample
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,  // estimate, error
   output logic [0:0]                rsp_tuser,  // saturated
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [STEP_WIDTH-1:0]     csr_wdata   // step_size
);

   ctl_type                        ctl;
   logic                           hist_we;
   addr_type                       hist_waddr, hist_raddr;
   logic        [SAMPLE_WIDTH-1:0] hist_wdata;
   logic        [SAMPLE_WIDTH-1:0] hist_rdata;
   logic                           coef_we;
   addr_type                       coef_waddr;
   logic        [COEF_WIDTH-1:0]   coef_wdata, coef_rdata;
   logic signed [SAMPLE_WIDTH-1:0] rsp_estimate, rsp_error;
   logic                           rsp_saturated;
   logic        [STEP_WIDTH-1:0]   step_ff, step_in;

   // Step-size register; written on every transfer of the csr channel.
   assign csr_ready = 1'b1;
   assign step_in   = (csr_valid && csr_ready) ? csr_wdata : step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else begin
         step_ff <= step_in;
      end
   end

   lmsfir_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .ref_sample (req_tdata[SAMPLE_WIDTH-1:0]),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .ctl        (ctl),
      .hist_we    (hist_we),
      .hist_waddr (hist_waddr),
      .hist_wdata (hist_wdata),
      .hist_raddr (hist_raddr)
   );

   lmsfir_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (TAPS)
   ) u_hist_ram (
      .clock (clock),
      .we    (hist_we),
      .waddr (hist_waddr),
      .wdata (hist_wdata),
      .raddr (hist_raddr),
      .rdata (hist_rdata)
   );

   lmsfir_ram #(
      .WIDTH (COEF_WIDTH),
      .DEPTH (TAPS)
   ) u_coef_ram (
      .clock (clock),
      .we    (coef_we),
      .waddr (coef_waddr),
      .wdata (coef_wdata),
      .raddr (ctl.idx),
      .rdata (coef_rdata)
   );

   lmsfir_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .step_size       (step_ff),
      .measured_sample (req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
      .coef_rdata      (coef_rdata),
      .hist_rdata      (hist_rdata),
      .coef_we         (coef_we),
      .coef_waddr      (coef_waddr),
      .coef_wdata      (coef_wdata),
      .rsp_estimate    (rsp_estimate),
      .rsp_error       (rsp_error),
      .rsp_saturated   (rsp_saturated)
   );

   // Result payload, estimate in the low half.
   assign rsp_tdata = RSP_DATA_WIDTH'({rsp_error, rsp_estimate});
   assign rsp_tuser = rsp_saturated;

   // Update write-back never lands on the entry being read in the same cycle.
   `LMSFIR_ASSERT_IMPLIES(a_coef_rw_apart, ctl.upd_issue && coef_we, coef_waddr != ctl.idx)
   // An input transfer starts the dot-product sweep at tap zero.
   `LMSFIR_ASSERT_NEXT(a_dot_starts, req_tvalid && req_tready, ctl.dot_issue && (ctl.idx == '0))
   // A result is only loaded when the output register is free or being drained.
   `LMSFIR_ASSERT_IMPLIES(a_out_free, ctl.out_load, !rsp_tvalid || rsp_tready)
   // Sequencer commands are mutually exclusive.
   `LMSFIR_ASSERT_ALWAYS(a_cmd_excl, $onehot0({ctl.start, ctl.dot_issue, ctl.upd_issue, ctl.finish, ctl.scale, ctl.clear, ctl.out_load}))

endmodule
